### rtl/core/efp_pkg.sv
// ----------------------------------------------------------------------------
// efp_pkg
// Shared types, constants and helpers of the escape-time fractal pixel block.
// ----------------------------------------------------------------------------
`default_nettype none

package efp_pkg;

   localparam int PIX_W      = 10;
   localparam int WORD_W     = 32;
   localparam int STEP_W     = 31;
   localparam int FRAC_W     = 26;
   localparam int ITER_W     = 7;
   localparam int COLOR_W    = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int WIDE_W     = 44;

   localparam int DEF_IMG_WIDTH  = 1024;
   localparam int DEF_IMG_HEIGHT = 1024;
   localparam int DEF_MAX_ITER   = 100;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [COLOR_W-1:0] BASE_COLOR = 21'h123456;
   localparam logic [38:0]        ESCAPE_SQ  = 39'd1 << (FRAC_W + 2);

   typedef enum logic [1:0] {
      MODE_MANDEL = 2'd0,
      MODE_JULIA  = 2'd1,
      MODE_BURN   = 2'd2,
      MODE_NONE   = 2'd3
   } efp_mode_type;

   localparam logic [CSR_IDX_W-1:0] REG_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RSTEP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ISTEP   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_JULIA_R = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_JULIA_I = 3'd6;

   typedef struct packed {
      efp_mode_type              mode;
      logic signed [WORD_W-1:0]  left;
      logic signed [WORD_W-1:0]  top;
      logic [STEP_W-1:0]         rstep;
      logic [STEP_W-1:0]         istep;
      logic signed [WORD_W-1:0]  julia_r;
      logic signed [WORD_W-1:0]  julia_i;
   } efp_cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0]          x;
      logic [PIX_W-1:0]          y;
      logic                      bypass;
      efp_mode_type              mode;
      logic signed [WORD_W-1:0]  zr;
      logic signed [WORD_W-1:0]  zi;
      logic signed [WORD_W-1:0]  cr;
      logic signed [WORD_W-1:0]  ci;
   } efp_item_type;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      if (v > $signed({{(WIDE_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}})) begin
         r = {1'b0, {(WORD_W-1){1'b1}}};
      end else if (v < $signed({{(WIDE_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}})) begin
         r = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/escape_time_fractal_pixel.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// Escape-time fractal pixel evaluator: Mandelbrot, Julia and Burning Ship.
// ----------------------------------------------------------------------------
// A pixel is taken when start is high and busy is low. The front maps it to
// the complex plane and parks it in a two-entry queue, so new pixels are
// taken while the back is still iterating. Each iteration of the back has a
// state for the shared multiplier set and a state for the escape test and
// update; a pixel that escapes then goes through the one-bit-per-cycle color
// divider, a pixel that stays inside ends after MAX_ITER iterations, and a
// pixel outside the image or in the unused mode is not iterated. Each result
// is shown for exactly one cycle with rsp_strobe high; the receiver cannot
// hold it off. Configuration writes are always taken (csr_ready stays high)
// and must only happen while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_time_fractal_pixel import efp_pkg::*; #(
   parameter int IMG_WIDTH  = DEF_IMG_WIDTH,
   parameter int IMG_HEIGHT = DEF_IMG_HEIGHT,
   parameter int MAX_ITER   = DEF_MAX_ITER
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [PIX_W-1:0]      req_pixel_x,
   input  wire logic [PIX_W-1:0]      req_pixel_y,
   output logic                       rsp_strobe,
   output logic [PIX_W-1:0]           rsp_out_x,
   output logic [PIX_W-1:0]           rsp_out_y,
   output logic [ITER_W-1:0]          rsp_iter_count,
   output logic                       rsp_is_inside,
   output logic [COLOR_W-1:0]         rsp_pixel_color,
   output logic                       rsp_write_enable,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [WORD_W-1:0]     csr_data
);

   efp_mode_type              mode_ff, mode_in;
   logic signed [WORD_W-1:0]  left_ff, left_in;
   logic signed [WORD_W-1:0]  top_ff, top_in;
   logic [STEP_W-1:0]         rstep_ff, rstep_in;
   logic [STEP_W-1:0]         istep_ff, istep_in;
   logic signed [WORD_W-1:0]  julia_r_ff, julia_r_in;
   logic signed [WORD_W-1:0]  julia_i_ff, julia_i_in;
   efp_cfg_type               cfg;
   logic                      push;
   efp_item_type              push_item;
   logic                      q_full;
   logic                      q_pop;
   efp_item_type              q_item;
   logic                      q_not_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in    = mode_ff;
      left_in    = left_ff;
      top_in     = top_ff;
      rstep_in   = rstep_ff;
      istep_in   = istep_ff;
      julia_r_in = julia_r_ff;
      julia_i_in = julia_i_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MODE:    mode_in    = efp_mode_type'(csr_data[1:0]);
            REG_LEFT:    left_in    = csr_data;
            REG_TOP:     top_in     = csr_data;
            REG_RSTEP:   rstep_in   = csr_data[STEP_W-1:0];
            REG_ISTEP:   istep_in   = csr_data[STEP_W-1:0];
            REG_JULIA_R: julia_r_in = csr_data;
            REG_JULIA_I: julia_i_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_MANDEL;
         left_ff    <= -32'sd134217728;
         top_ff     <= 32'sd134217728;
         rstep_ff   <= 31'd262144;
         istep_ff   <= 31'd262144;
         julia_r_ff <= '0;
         julia_i_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         left_ff    <= left_in;
         top_ff     <= top_in;
         rstep_ff   <= rstep_in;
         istep_ff   <= istep_in;
         julia_r_ff <= julia_r_in;
         julia_i_ff <= julia_i_in;
      end
   end

   always_comb begin
      cfg.mode    = mode_ff;
      cfg.left    = left_ff;
      cfg.top     = top_ff;
      cfg.rstep   = rstep_ff;
      cfg.istep   = istep_ff;
      cfg.julia_r = julia_r_ff;
      cfg.julia_i = julia_i_ff;
   end

   efp_front #(
      .IMG_WIDTH  (IMG_WIDTH),
      .IMG_HEIGHT (IMG_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .cfg         (cfg),
      .q_full      (q_full),
      .push        (push),
      .push_item   (push_item)
   );

   efp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .not_empty (q_not_empty)
   );

   efp_back #(
      .MAX_ITER (MAX_ITER)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_iter_count   (rsp_iter_count),
      .rsp_is_inside    (rsp_is_inside),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_write_enable (rsp_write_enable)
   );

endmodule

`default_nettype wire

### rtl/core/efp_front.sv
// ----------------------------------------------------------------------------
// efp_front
// Accepts pixels, maps them to the complex plane and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module efp_front import efp_pkg::*; #(
   parameter int IMG_WIDTH  = DEF_IMG_WIDTH,
   parameter int IMG_HEIGHT = DEF_IMG_HEIGHT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [PIX_W-1:0]   req_pixel_x,
   input  wire logic [PIX_W-1:0]   req_pixel_y,
   input  wire efp_cfg_type        cfg,
   input  wire logic               q_full,
   output logic                    push,
   output efp_item_type            push_item
);

   localparam int PROD_W = PIX_W + STEP_W;

   logic                     s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]         s1_x_ff, s1_x_in;
   logic [PIX_W-1:0]         s1_y_ff, s1_y_in;
   logic [PROD_W-1:0]        s1_prod_r_ff, s1_prod_r_in;
   logic [PROD_W-1:0]        s1_prod_i_ff, s1_prod_i_in;
   logic                     s1_bypass_ff, s1_bypass_in;
   efp_mode_type             s1_mode_ff, s1_mode_in;
   logic                     accept;
   logic signed [WIDE_W-1:0] pr_wide;
   logic signed [WIDE_W-1:0] pi_wide;
   logic signed [WORD_W-1:0] pr;
   logic signed [WORD_W-1:0] pi;

   assign push   = s1_valid_ff && !q_full;
   assign busy   = s1_valid_ff && q_full;
   assign accept = start && !busy;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_x_in      = s1_x_ff;
      s1_y_in      = s1_y_ff;
      s1_prod_r_in = s1_prod_r_ff;
      s1_prod_i_in = s1_prod_i_ff;
      s1_bypass_in = s1_bypass_ff;
      s1_mode_in   = s1_mode_ff;
      if (push) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_x_in      = req_pixel_x;
         s1_y_in      = req_pixel_y;
         s1_prod_r_in = PROD_W'(req_pixel_x) * PROD_W'(cfg.rstep);
         s1_prod_i_in = PROD_W'(req_pixel_y) * PROD_W'(cfg.istep);
         s1_mode_in   = cfg.mode;
         s1_bypass_in = (cfg.mode == MODE_NONE)
                     || ({{(WORD_W-PIX_W){1'b0}}, req_pixel_x} >= WORD_W'(IMG_WIDTH))
                     || ({{(WORD_W-PIX_W){1'b0}}, req_pixel_y} >= WORD_W'(IMG_HEIGHT));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_x_ff      <= s1_x_in;
      s1_y_ff      <= s1_y_in;
      s1_prod_r_ff <= s1_prod_r_in;
      s1_prod_i_ff <= s1_prod_i_in;
      s1_bypass_ff <= s1_bypass_in;
      s1_mode_ff   <= s1_mode_in;
   end

   always_comb begin
      pr_wide = {{(WIDE_W-WORD_W){cfg.left[WORD_W-1]}}, cfg.left}
              + $signed({{(WIDE_W-PROD_W){1'b0}}, s1_prod_r_ff});
      pi_wide = {{(WIDE_W-WORD_W){cfg.top[WORD_W-1]}}, cfg.top}
              - $signed({{(WIDE_W-PROD_W){1'b0}}, s1_prod_i_ff});
      pr = sat_word(pr_wide);
      pi = sat_word(pi_wide);
      push_item.x      = s1_x_ff;
      push_item.y      = s1_y_ff;
      push_item.bypass = s1_bypass_ff;
      push_item.mode   = s1_mode_ff;
      if (s1_mode_ff == MODE_JULIA) begin
         push_item.zr = pr;
         push_item.zi = pi;
         push_item.cr = cfg.julia_r;
         push_item.ci = cfg.julia_i;
      end else begin
         push_item.zr = '0;
         push_item.zi = '0;
         push_item.cr = pr;
         push_item.ci = pi;
      end
   end

endmodule

`default_nettype wire

### rtl/core/efp_queue.sv
// ----------------------------------------------------------------------------
// efp_queue
// Short first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module efp_queue import efp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire efp_item_type  push_item,
   output logic               full,
   input  wire logic          pop,
   output efp_item_type       pop_item,
   output logic               not_empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   efp_item_type    item_mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = item_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_mem[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue write while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

### rtl/core/efp_back.sv
// ----------------------------------------------------------------------------
// efp_back
// Iterates the escape-time recurrence on one shared multiplier set and
// derives the pixel color with a bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module efp_back import efp_pkg::*; #(
   parameter int MAX_ITER = DEF_MAX_ITER
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_not_empty,
   input  wire efp_item_type       q_item,
   output logic                    q_pop,
   output logic                    rsp_strobe,
   output logic [PIX_W-1:0]        rsp_out_x,
   output logic [PIX_W-1:0]        rsp_out_y,
   output logic [ITER_W-1:0]       rsp_iter_count,
   output logic                    rsp_is_inside,
   output logic [COLOR_W-1:0]      rsp_pixel_color,
   output logic                    rsp_write_enable
);

   localparam int NW = $clog2(MAX_ITER + 1);
   localparam int DW = NW + 1;
   localparam int KW = $clog2(COLOR_W);
   localparam int PW = 2 * WORD_W;
   localparam int SW = PW - FRAC_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_UPD  = 4'b0100,
      S_DIV  = 4'b1000
   } back_state_type;

   back_state_type            state_ff, state_in;
   logic signed [WORD_W-1:0]  zr_ff, zr_in;
   logic signed [WORD_W-1:0]  zi_ff, zi_in;
   logic signed [WORD_W-1:0]  cr_ff, cr_in;
   logic signed [WORD_W-1:0]  ci_ff, ci_in;
   efp_mode_type              mode_ff, mode_in;
   logic [PIX_W-1:0]          x_ff, x_in;
   logic [PIX_W-1:0]          y_ff, y_in;
   logic [NW-1:0]             n_ff, n_in;
   logic signed [PW-1:0]      psq_r_ff, psq_r_in;
   logic signed [PW-1:0]      psq_i_ff, psq_i_in;
   logic signed [PW-1:0]      pcross_ff, pcross_in;
   logic [COLOR_W-1:0]        q_ff, q_in;
   logic [DW-1:0]             rem_ff, rem_in;
   logic [DW-1:0]             dvs_ff, dvs_in;
   logic [KW-1:0]             cnt_ff, cnt_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [PIX_W-1:0]          rsp_x_ff, rsp_x_in;
   logic [PIX_W-1:0]          rsp_y_ff, rsp_y_in;
   logic [ITER_W-1:0]         rsp_iter_ff, rsp_iter_in;
   logic                      rsp_inside_ff, rsp_inside_in;
   logic [COLOR_W-1:0]        rsp_color_ff, rsp_color_in;
   logic                      rsp_we_ff, rsp_we_in;

   logic [SW-1:0]             sr;
   logic [SW-1:0]             si;
   logic [SW:0]               sum_sq;
   logic                      escape;
   logic signed [PW-1:0]      cross_abs;
   logic signed [PW-1:0]      cross_sh;
   logic signed [WIDE_W-1:0]  zr_wide;
   logic signed [WIDE_W-1:0]  zi_wide;
   logic [DW:0]               rem_sh;

   always_comb begin
      sr       = psq_r_ff[PW-1:FRAC_W];
      si       = psq_i_ff[PW-1:FRAC_W];
      sum_sq   = {1'b0, sr} + {1'b0, si};
      escape   = (sum_sq >= ESCAPE_SQ);
      cross_abs = ((mode_ff == MODE_BURN) && pcross_ff[PW-1]) ? -pcross_ff : pcross_ff;
      cross_sh = cross_abs >>> (FRAC_W - 1);
      zr_wide  = $signed({{(WIDE_W-SW){1'b0}}, sr}) - $signed({{(WIDE_W-SW){1'b0}}, si})
               + {{(WIDE_W-WORD_W){cr_ff[WORD_W-1]}}, cr_ff};
      zi_wide  = cross_sh[WIDE_W-1:0]
               + {{(WIDE_W-WORD_W){ci_ff[WORD_W-1]}}, ci_ff};
      rem_sh   = {rem_ff, q_ff[COLOR_W-1]};
   end

   always_comb begin
      state_in      = state_ff;
      zr_in         = zr_ff;
      zi_in         = zi_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      mode_in       = mode_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      n_in          = n_ff;
      psq_r_in      = psq_r_ff;
      psq_i_in      = psq_i_ff;
      pcross_in     = pcross_ff;
      q_in          = q_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_iter_in   = rsp_iter_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_we_in     = rsp_we_ff;
      q_pop         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               q_pop   = 1'b1;
               zr_in   = q_item.zr;
               zi_in   = q_item.zi;
               cr_in   = q_item.cr;
               ci_in   = q_item.ci;
               mode_in = q_item.mode;
               x_in    = q_item.x;
               y_in    = q_item.y;
               n_in    = '0;
               if (q_item.bypass) begin
                  rsp_strobe_in = 1'b1;
                  rsp_x_in      = q_item.x;
                  rsp_y_in      = q_item.y;
                  rsp_iter_in   = '0;
                  rsp_inside_in = 1'b0;
                  rsp_color_in  = '0;
                  rsp_we_in     = 1'b0;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (n_ff == NW'(MAX_ITER)) begin
               rsp_strobe_in = 1'b1;
               rsp_x_in      = x_ff;
               rsp_y_in      = y_ff;
               rsp_iter_in   = ITER_W'(n_ff);
               rsp_inside_in = 1'b1;
               rsp_color_in  = '0;
               rsp_we_in     = (mode_ff != MODE_JULIA);
               state_in      = S_IDLE;
            end else begin
               psq_r_in  = zr_ff * zr_ff;
               psq_i_in  = zi_ff * zi_ff;
               pcross_in = zr_ff * zi_ff;
               state_in  = S_UPD;
            end
         end
         S_UPD: begin
            if (escape) begin
               dvs_in   = (mode_ff == MODE_MANDEL) ? {1'b0, n_ff} : {1'b0, n_ff} + 1'b1;
               q_in     = BASE_COLOR;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end else begin
               zr_in    = sat_word(zr_wide);
               zi_in    = sat_word(zi_wide);
               n_in     = n_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_DIV: begin
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = DW'(rem_sh - {1'b0, dvs_ff});
               q_in   = {q_ff[COLOR_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DW-1:0];
               q_in   = {q_ff[COLOR_W-2:0], 1'b0};
            end
            if (cnt_ff == KW'(COLOR_W - 1)) begin
               rsp_strobe_in = 1'b1;
               rsp_x_in      = x_ff;
               rsp_y_in      = y_ff;
               rsp_iter_in   = ITER_W'(n_ff);
               rsp_inside_in = 1'b0;
               rsp_color_in  = (dvs_ff == '0) ? '0 : q_in;
               rsp_we_in     = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         n_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         n_ff          <= n_in;
      end
      zr_ff         <= zr_in;
      zi_ff         <= zi_in;
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      mode_ff       <= mode_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      psq_r_ff      <= psq_r_in;
      psq_i_ff      <= psq_i_in;
      pcross_ff     <= pcross_in;
      q_ff          <= q_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      cnt_ff        <= cnt_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_iter_ff   <= rsp_iter_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_we_ff     <= rsp_we_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_out_x        = rsp_x_ff;
   assign rsp_out_y        = rsp_y_ff;
   assign rsp_iter_count   = rsp_iter_ff;
   assign rsp_is_inside    = rsp_inside_ff;
   assign rsp_pixel_color  = rsp_color_ff;
   assign rsp_write_enable = rsp_we_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == S_IDLE))
      else $error("result strobed while a pixel is still in work");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NW'(MAX_ITER))
      else $error("iteration count beyond limit");

   a_inside_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_inside_ff) |-> (rsp_color_ff == '0))
      else $error("inside pixel with nonzero color");

endmodule

`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for escape_time_fractal_pixel. Pixels go in through the
// start/busy handshake and register writes through the csr channel. The bench
// changes the view, the mode and the Julia constant between phases while the
// block is idle. A scoreboard computes the iteration count, inside flag,
// color and write enable of every accepted pixel and matches each strobed
// result, in order, against that prediction.
// ----------------------------------------------------------------------------
module testbench;
   import efp_pkg::*;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_ITEMS = 750;
   localparam int CALM_TAIL    = 150;
   localparam int DRAIN_CYCLES = 250;
   localparam int Q_ONE        = 1 << FRAC_W;

   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic [STEP_W-1:0]        STEP_MAX = 31'h7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] HOME_LEFT = -32'sd134217728;
   localparam logic signed [WORD_W-1:0] HOME_TOP  = 32'sd134217728;
   localparam logic [STEP_W-1:0]        HOME_STEP = 31'd262144;

   typedef struct {
      logic [PIX_W-1:0]   x;
      logic [PIX_W-1:0]   y;
      logic [ITER_W-1:0]  iters;
      logic               interior;
      logic [COLOR_W-1:0] color;
      logic               wr_en;
   } pixel_result_type;

   class fractal_scoreboard;
      localparam longint ESCAPE_LIMIT = longint'(4) << FRAC_W;

      efp_mode_type             mode;
      logic signed [WORD_W-1:0] left;
      logic signed [WORD_W-1:0] top;
      logic [STEP_W-1:0]        rstep;
      logic [STEP_W-1:0]        istep;
      logic signed [WORD_W-1:0] julia_r;
      logic signed [WORD_W-1:0] julia_i;
      pixel_result_type         awaited[$];
      int                       mismatches;

      function new();
         mode       = MODE_MANDEL;
         left       = HOME_LEFT;
         top        = HOME_TOP;
         rstep      = HOME_STEP;
         istep      = HOME_STEP;
         julia_r    = '0;
         julia_i    = '0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
         case (idx)
            REG_MODE:    mode = efp_mode_type'(data[1:0]);
            REG_LEFT:    left = data;
            REG_TOP:     top = data;
            REG_RSTEP:   rstep = data[STEP_W-1:0];
            REG_ISTEP:   istep = data[STEP_W-1:0];
            REG_JULIA_R: julia_r = data;
            REG_JULIA_I: julia_i = data;
            default: ;
         endcase
      endfunction

      function logic signed [WORD_W-1:0] clamp_word(longint v);
         if (v > longint'(WORD_MAX)) begin
            return WORD_MAX;
         end
         if (v < longint'(WORD_MIN)) begin
            return WORD_MIN;
         end
         return v[WORD_W-1:0];
      endfunction

      function pixel_result_type escape_time(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
         pixel_result_type         r;
         longint                   sr;
         longint                   si;
         longint                   xprod;
         logic signed [WORD_W-1:0] pr;
         logic signed [WORD_W-1:0] pi;
         logic signed [WORD_W-1:0] zr;
         logic signed [WORD_W-1:0] zi;
         logic signed [WORD_W-1:0] cr;
         logic signed [WORD_W-1:0] ci;
         int                       n;
         int                       div;
         int                       base;
         r.x        = x;
         r.y        = y;
         r.iters    = '0;
         r.interior = 1'b0;
         r.color    = '0;
         r.wr_en    = 1'b0;
         if (mode == MODE_NONE || x >= DEF_IMG_WIDTH || y >= DEF_IMG_HEIGHT) begin
            return r;
         end
         pr = clamp_word(longint'(left) + longint'(x) * longint'(rstep));
         pi = clamp_word(longint'(top) - longint'(y) * longint'(istep));
         if (mode == MODE_JULIA) begin
            zr = pr;
            zi = pi;
            cr = julia_r;
            ci = julia_i;
         end else begin
            zr = '0;
            zi = '0;
            cr = pr;
            ci = pi;
         end
         n = 0;
         while (n < DEF_MAX_ITER) begin
            sr    = (longint'(zr) * longint'(zr)) >>> FRAC_W;
            si    = (longint'(zi) * longint'(zi)) >>> FRAC_W;
            xprod = longint'(zr) * longint'(zi);
            if (sr + si >= ESCAPE_LIMIT) begin
               break;
            end
            if (mode == MODE_BURN && xprod < 0) begin
               xprod = -xprod;
            end
            xprod = xprod >>> (FRAC_W - 1);
            zr    = clamp_word(sr - si + longint'(cr));
            zi    = clamp_word(xprod + longint'(ci));
            n++;
         end
         r.iters    = n[ITER_W-1:0];
         r.interior = (n == DEF_MAX_ITER);
         r.wr_en    = 1'b1;
         if (r.interior) begin
            if (mode == MODE_JULIA) begin
               r.wr_en = 1'b0;
            end
         end else begin
            base = int'(BASE_COLOR);
            div  = (mode == MODE_MANDEL) ? n : n + 1;
            if (div != 0) begin
               r.color = COLOR_W'(base / div);
            end
         end
         return r;
      endfunction

      function void note_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
         awaited.push_back(escape_time(x, y));
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void check_result(pixel_result_type got);
         pixel_result_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: x=%0d y=%0d n=%0d in=%0b color=%06h we=%0b",
                        got.x, got.y, got.iters, got.interior, got.color, got.wr_en);
            end
            return;
         end
         want = awaited.pop_front();
         if (got.x !== want.x || got.y !== want.y || got.iters !== want.iters ||
             got.interior !== want.interior || got.color !== want.color ||
             got.wr_en !== want.wr_en) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected x=%0d y=%0d n=%0d in=%0b color=%06h we=%0b",
                        want.x, want.y, want.iters, want.interior, want.color, want.wr_en);
               $display("          actual   x=%0d y=%0d n=%0d in=%0b color=%06h we=%0b",
                        got.x, got.y, got.iters, got.interior, got.color, got.wr_en);
            end
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [PIX_W-1:0]     req_pixel_x = '0;
   logic [PIX_W-1:0]     req_pixel_y = '0;
   logic                 rsp_strobe;
   logic [PIX_W-1:0]     rsp_out_x;
   logic [PIX_W-1:0]     rsp_out_y;
   logic [ITER_W-1:0]    rsp_iter_count;
   logic                 rsp_is_inside;
   logic [COLOR_W-1:0]   rsp_pixel_color;
   logic                 rsp_write_enable;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_data = '0;

   fractal_scoreboard    board;
   pixel_result_type     seen;
   int unsigned          cycles = 0;

   escape_time_fractal_pixel uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_iter_count   (rsp_iter_count),
      .rsp_is_inside    (rsp_is_inside),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_write_enable (rsp_write_enable),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen.x        = rsp_out_x;
         seen.y        = rsp_out_y;
         seen.iters    = rsp_iter_count;
         seen.interior = rsp_is_inside;
         seen.color    = rsp_pixel_color;
         seen.wr_en    = rsp_write_enable;
         board.check_result(seen);
      end
   end

   // start stays high on return; the next call or a pause decides its level
   task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
      @(negedge clock);
      start       <= 1'b1;
      req_pixel_x <= x;
      req_pixel_y <= y;
      forever begin
         @(posedge clock);
         if (!busy) begin
            break;
         end
      end
      board.note_pixel(x, y);
   endtask

   task automatic sender_gap(int len);
      @(negedge clock);
      start <= 1'b0;
      repeat (len - 1) @(negedge clock);
   endtask

   // hold start low until every pixel in flight has come back
   task automatic drain_pixels();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      forever begin
         @(posedge clock);
         if (csr_ready) begin
            break;
         end
      end
      board.write_reg(idx, data);
   endtask

   task automatic set_view(efp_mode_type m, logic signed [WORD_W-1:0] l,
                           logic signed [WORD_W-1:0] t, logic [STEP_W-1:0] rs,
                           logic [STEP_W-1:0] is, logic signed [WORD_W-1:0] jr,
                           logic signed [WORD_W-1:0] ji);
      drain_pixels();
      write_csr(REG_MODE, {30'b0, m});
      write_csr(REG_LEFT, l);
      write_csr(REG_TOP, t);
      write_csr(REG_RSTEP, {1'b0, rs});
      write_csr(REG_ISTEP, {1'b0, is});
      write_csr(REG_JULIA_R, jr);
      write_csr(REG_JULIA_I, ji);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_view();
      efp_mode_type             m;
      logic signed [WORD_W-1:0] l;
      logic signed [WORD_W-1:0] t;
      logic signed [WORD_W-1:0] jr;
      logic signed [WORD_W-1:0] ji;
      logic [STEP_W-1:0]        rs;
      logic [STEP_W-1:0]        is;
      int                       pick;
      int                       mid_r;
      int                       mid_i;
      pick = $urandom_range(0, 15);
      m = (pick < 6) ? MODE_MANDEL : (pick < 11) ? MODE_JULIA :
          (pick < 15) ? MODE_BURN : MODE_NONE;
      if ($urandom_range(0, 7) == 0) begin
         l  = $urandom;
         t  = $urandom;
         rs = STEP_W'($urandom);
         is = STEP_W'($urandom);
         jr = $urandom;
         ji = $urandom;
      end else begin
         rs = STEP_W'($urandom_range(1 << 8, 1 << 19));
         is = ($urandom_range(0, 3) == 0) ? STEP_W'($urandom_range(1 << 8, 1 << 19)) : rs;
         mid_r = int'($urandom_range(0, 214748364)) - 147639500;
         mid_i = int'($urandom_range(0, 201326592)) - 100663296;
         l  = mid_r - 512 * int'(rs);
         t  = mid_i + 512 * int'(is);
         jr = int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
         ji = int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
      end
      set_view(m, l, t, rs, is, jr, ji);
   endtask

   task automatic run_directed();
      // reset view
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd256, 10'd512);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd0, 10'd1023);
      // julia with zero constant: origin stays inside, corner escapes at once
      set_view(MODE_JULIA, HOME_LEFT, HOME_TOP, HOME_STEP, HOME_STEP, '0, '0);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd0, 10'd0);
      set_view(MODE_JULIA, HOME_LEFT, HOME_TOP, HOME_STEP, HOME_STEP,
               -32'sd53687091, 32'sd10468982);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd700, 10'd400);
      set_view(MODE_BURN, HOME_LEFT, HOME_TOP, HOME_STEP, HOME_STEP, '0, '0);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd300, 10'd450);
      send_pixel(10'd400, 10'd600);
      set_view(MODE_NONE, HOME_LEFT, HOME_TOP, HOME_STEP, HOME_STEP, '0, '0);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd1023, 10'd3);
      // saturating coordinates
      set_view(MODE_MANDEL, WORD_MIN, WORD_MAX, STEP_MAX, STEP_MAX, WORD_MIN, WORD_MAX);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd1, 10'd1);
      set_view(MODE_BURN, WORD_MAX, WORD_MIN, '0, '0, WORD_MAX, WORD_MIN);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      set_view(MODE_JULIA, '0, '0, '0, '0, WORD_MAX, WORD_MIN);
      send_pixel(10'd7, 10'd7);
      set_view(MODE_JULIA, '0, '0, '0, '0, WORD_MIN, WORD_MAX);
      send_pixel(10'd0, 10'd0);
   endtask

   initial begin
      int sent;
      int budget;
      board = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         random_view();
         budget = (sent >= RANDOM_ITEMS - CALM_TAIL) ? RANDOM_ITEMS - sent :
                  $urandom_range(12, 40);
         repeat (budget) begin
            if (sent >= RANDOM_ITEMS) begin
               break;
            end
            if (sent < RANDOM_ITEMS - CALM_TAIL) begin
               if ($urandom_range(0, 4) == 0) begin
                  sender_gap($urandom_range(1, 17));
               end else if ($urandom_range(0, 59) == 0) begin
                  drain_pixels();
               end
            end
            send_pixel(PIX_W'($urandom_range(0, 1023)), PIX_W'($urandom_range(0, 1023)));
            sent++;
         end
      end
      @(negedge clock);
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/efp_pkg.sv
rtl/core/efp_front.sv
rtl/core/efp_queue.sv
rtl/core/efp_back.sv
rtl/core/escape_time_fractal_pixel.sv
test/testbench.sv
